// ----- src/tlsf_pkg.sv -----
// Shared types for the TLSF bitmap bin index block.
// Holds the command codes, the request and response payloads and the
// controller/datapath command and status bundles. No dependencies.
package tlsf_pkg;

   // Command codes carried by each request.
   typedef enum logic [1:0] {
      CMD_SEARCH = 2'd0,
      CMD_INSERT = 2'd1,
      CMD_REMOVE = 2'd2,
      CMD_UNUSED = 2'd3
   } command_type;

   // Configuration register width.
   localparam int SUB_BITS_W = 3;

   // Reset value of the sub-bin bits register.
   localparam logic [SUB_BITS_W-1:0] SUB_BITS_RESET = 3'd4;

   // Request payload.
   typedef struct packed {
      logic [1:0]  command;
      logic [31:0] block_size;
   } req_type;

   // Response payload.
   typedef struct packed {
      logic       found;
      logic [4:0] first_level;
      logic [4:0] second_level;
      logic       size_zero;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_req;
      logic map;
      logic exec;
      logic row_done;
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic need_row;
   } dp_status_type;

endpackage

// ----- src/tlsf_bitmap_bin_index.sv -----
// rsp_valid is registered. A request is captured in ST_IDLE, mapped with a row read in
// ST_MAP, applied in ST_EXEC and, when a search must fetch a higher row, finished in ST_ROW.
// A new request is taken only once the previous one has finished, and a response held
// by the receiver stalls the update.
// Reset clears the first-level bitmap and, through per-row valid bits, the row store, and
// sets sub_bin_bits to 4; no clearing pass is needed.
module tlsf_bitmap_bin_index #(
   parameter int SIZE_BITS    = 32,
   parameter int MAX_SUB_BINS = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  tlsf_pkg::req_type               req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output tlsf_pkg::rsp_type               rsp_data,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [tlsf_pkg::SUB_BITS_W-1:0] csr_wdata
);
   import tlsf_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   // The configuration register accepts a write in every cycle.
   assign csr_ready = 1'b1;

   // Controller.
   tlsf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Datapath.
   tlsf_datapath #(
      .SIZE_BITS    (SIZE_BITS),
      .MAX_SUB_BINS (MAX_SUB_BINS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_we    (csr_valid && csr_ready),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .status    (status),
      .rsp_data  (rsp_data)
   );

   // The controller issues at most one datapath command per cycle.
   assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load_req, cmd.map, cmd.exec, cmd.row_done}))
      else $error("more than one datapath command at once");

   // A request transfer is always followed by the size mapping step.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> cmd.map)
      else $error("mapping step missing after request transfer");

   // Only one item is in flight: no request is taken in the following cycle.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while an item is in flight");

endmodule

// ----- src/tlsf_ctrl.sv -----
// Controller state machine for the TLSF bitmap bin index block.
// Sequences capture, size mapping, bitmap update and the optional row fetch.
// Depends on tlsf_pkg.
module tlsf_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  tlsf_pkg::dp_status_type status,
   output tlsf_pkg::ctrl_cmd_type  cmd
);
   import tlsf_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_MAP  = 4'b0010,
      ST_EXEC = 4'b0100,
      ST_ROW  = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_busy;
   logic      finish;

   // The result register is busy while it holds a result not taken this cycle.
   assign out_busy = rsp_valid_ff && !rsp_ready;

   // Next state and command decode.
   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      req_ready    = 1'b0;
      finish       = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = ST_MAP;
            end
         end
         ST_MAP: begin
            cmd.map  = 1'b1;
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (!out_busy) begin
               cmd.exec = 1'b1;
               if (status.need_row) begin
                  state_in = ST_ROW;
               end else begin
                  finish   = 1'b1;
                  state_in = ST_IDLE;
               end
            end
         end
         ST_ROW: begin
            if (!out_busy) begin
               cmd.row_done = 1'b1;
               finish       = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // A finished item fills the result slot; a transfer empties it.
   assign rsp_valid_in = finish || out_busy;
   assign rsp_valid    = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ----- src/tlsf_datapath.sv -----
// Datapath for the TLSF bitmap bin index block: size mapping, the
// first-level bitmap, the row bitmap store and the result register.
// Depends on tlsf_pkg.
module tlsf_datapath #(
   parameter int SIZE_BITS    = 32,
   parameter int MAX_SUB_BINS = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  tlsf_pkg::req_type                   req_data,
   input  logic                                csr_we,
   input  logic [tlsf_pkg::SUB_BITS_W-1:0]     csr_wdata,
   input  tlsf_pkg::ctrl_cmd_type              cmd,
   output tlsf_pkg::dp_status_type             status,
   output tlsf_pkg::rsp_type                   rsp_data
);
   import tlsf_pkg::*;

   localparam int MAX_SB   = $clog2(MAX_SUB_BINS + 1) - 1;
   localparam int ROW_W    = 1 << MAX_SB;
   localparam int SL_W     = (MAX_SB > 0) ? MAX_SB : 1;
   localparam int ROWS     = (SIZE_BITS < 32) ? SIZE_BITS : 32;
   localparam int FL_W     = $clog2(ROWS);
   localparam logic [31:0] SIZE_MASK = 32'((64'd1 << ROWS) - 64'd1);

   // Lowest set bit of a word, zero when none is set.
   function automatic logic [5:0] lowest64(input logic [63:0] v);
      logic [5:0] r;
      r = 6'd0;
      for (int i = 63; i >= 0; i--) begin
         if (v[i]) begin
            r = 6'(i);
         end
      end
      return r;
   endfunction

   req_type              req_ff;
   logic [SUB_BITS_W-1:0] sub_bits_ff;
   logic [4:0]           fl_ff, fl_in;
   logic [SL_W-1:0]      sl_ff;
   logic                 fits_ff;
   logic [ROWS-1:0]      l1_ff, l1_in;
   logic [ROW_W-1:0]     row_mem [ROWS];
   logic [ROWS-1:0]      row_valid_ff;
   logic [ROW_W-1:0]     row_rd_ff;
   logic                 row_rd_valid_ff;
   rsp_type              rsp_ff, rsp_in;

   logic [31:0]          size_m;
   logic [2:0]           sb;
   logic [4:0]           top;
   logic [4:0]           sh;
   logic [31:0]          rest;
   logic [31:0]          shifted;
   logic                 fits_map;
   logic [FL_W-1:0]      fl_idx;
   logic [ROW_W-1:0]     row_cur;
   logic [ROW_W-1:0]     sl_bit;
   logic [ROW_W-1:0]     higher;
   logic [ROW_W-1:0]     wr_row;
   logic [ROWS-1:0]      rows_up;
   logic [5:0]           higher_low;
   logic [5:0]           rows_low;
   logic [5:0]           row_low;
   logic                 own_fits;
   logic                 need_row;
   logic                 wr_en;
   logic                 rd_en;
   logic [FL_W-1:0]      rd_addr;
   logic                 is_zero;

   // Input capture and configuration register.
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_ff <= req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sub_bits_ff <= SUB_BITS_RESET;
      end else if (csr_we) begin
         sub_bits_ff <= csr_wdata;
      end
   end

   // Size mapping: top set bit gives the row, the bits below give the sub-bin.
   always_comb begin
      size_m = req_ff.block_size & SIZE_MASK;
      sb     = (sub_bits_ff > 3'(MAX_SB)) ? 3'(MAX_SB) : sub_bits_ff;
      top    = 5'd0;
      for (int i = 0; i < 32; i++) begin
         if (size_m[i]) begin
            top = 5'(i);
         end
      end
      rest = size_m & ~(32'd1 << top);
      sh   = top - {2'b00, sb};
      if (top >= {2'b00, sb}) begin
         shifted  = rest >> sh;
         fits_map = (size_m & ((32'd1 << sh) - 32'd1)) == 32'd0;
      end else begin
         shifted  = rest;
         fits_map = 1'b1;
      end
      is_zero = size_m == 32'd0;
   end

   // Search and update logic over the fetched row.
   assign fl_idx     = fl_ff[FL_W-1:0];
   assign row_cur    = row_rd_valid_ff ? row_rd_ff : '0;
   assign sl_bit     = ROW_W'(1) << sl_ff;
   assign higher     = row_cur & (({ROW_W{1'b1}} << sl_ff) << 1);
   assign rows_up    = l1_ff & (({ROWS{1'b1}} << fl_idx) << 1);
   assign higher_low = lowest64(64'(higher));
   assign rows_low   = lowest64(64'(rows_up));
   assign row_low    = lowest64(64'(row_cur));
   assign own_fits   = ((row_cur & sl_bit) != '0) && fits_ff;

   assign need_row = (command_type'(req_ff.command) == CMD_SEARCH) && !own_fits
                     && (higher == '0) && (rows_up != '0);
   assign status.need_row = need_row;

   always_comb begin
      wr_en  = 1'b0;
      wr_row = row_cur;
      l1_in  = l1_ff;
      rsp_in = rsp_ff;
      if (cmd.exec) begin
         rsp_in.found        = 1'b1;
         rsp_in.first_level  = fl_ff;
         rsp_in.second_level = 5'(sl_ff);
         rsp_in.size_zero    = is_zero;
         case (command_type'(req_ff.command))
            CMD_SEARCH: begin
               if (own_fits) begin
                  rsp_in.second_level = 5'(sl_ff);
               end else if (higher != '0) begin
                  rsp_in.second_level = 5'(higher_low);
               end else if (rows_up == '0) begin
                  rsp_in.found        = 1'b0;
                  rsp_in.first_level  = 5'd0;
                  rsp_in.second_level = 5'd0;
               end
            end
            CMD_INSERT: begin
               wr_en         = 1'b1;
               wr_row        = row_cur | sl_bit;
               l1_in[fl_idx] = 1'b1;
            end
            CMD_REMOVE: begin
               wr_en  = 1'b1;
               wr_row = row_cur & ~sl_bit;
               if ((row_cur & ~sl_bit) == '0) begin
                  l1_in[fl_idx] = 1'b0;
               end
            end
            default: begin
               rsp_in.found = 1'b0;
            end
         endcase
      end else if (cmd.row_done) begin
         rsp_in.found        = 1'b1;
         rsp_in.first_level  = fl_ff;
         rsp_in.second_level = 5'(row_low);
         rsp_in.size_zero    = is_zero;
      end
   end

   // Row register: mapped row, then the higher row when the search moves on.
   always_comb begin
      fl_in = fl_ff;
      if (cmd.map) begin
         fl_in = top;
      end else if (cmd.exec && need_row) begin
         fl_in = 5'(rows_low);
      end
   end

   always_ff @(posedge clock) begin
      fl_ff <= fl_in;
      if (cmd.map) begin
         sl_ff   <= shifted[SL_W-1:0];
         fits_ff <= fits_map;
      end
      if ((cmd.exec && !need_row) || cmd.row_done) begin
         rsp_ff <= rsp_in;
      end
   end

   // First-level bitmap.
   always_ff @(posedge clock) begin
      if (reset) begin
         l1_ff <= '0;
      end else begin
         l1_ff <= l1_in;
      end
   end

   // Row bitmap store: one write and one registered read per cycle.
   assign rd_en   = cmd.map || (cmd.exec && need_row);
   assign rd_addr = cmd.map ? top[FL_W-1:0] : rows_low[FL_W-1:0];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         row_mem[fl_idx] <= wr_row;
      end
      if (rd_en) begin
         row_rd_ff <= row_mem[rd_addr];
      end
   end

   // Per-row valid bits stand for the all-zero reset contents of the store.
   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff    <= '0;
         row_rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            row_valid_ff[fl_idx] <= 1'b1;
         end
         if (rd_en) begin
            row_rd_valid_ff <= row_valid_ff[rd_addr];
         end
      end
   end

   assign rsp_data = rsp_ff;

endmodule
